[design/ffa_pkg.sv]
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants of the first-fit heap allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

    localparam int CMD_W    = 1;
    localparam int SIZE_W   = 16;
    localparam int OFF_W    = 12;
    localparam int STATUS_W = 2;
    localparam int TOT_W    = 12;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_A_CHK,
        S_A_RD,
        S_A_EVAL,
        S_A_SPLIT,
        S_A_TAKE,
        S_DN_RD,
        S_DN_WR,
        S_F_CHK,
        S_F_HDRCHK,
        S_F_RD,
        S_F_EVAL,
        S_UP_RD,
        S_UP_WR,
        S_F_HDR,
        S_RES
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_LOAD,
        OP_NEXT,
        OP_HIT,
        OP_SPLIT,
        OP_TAKE,
        OP_RD_NEXT,
        OP_DN_WR,
        OP_DEC,
        OP_LATCH_SPAN,
        OP_APPLY,
        OP_RD_PREV,
        OP_UP_WR,
        OP_UP_INS,
        OP_FREE_HDR
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic                result;   // load the output register
        logic [STATUS_W-1:0] code;
    } ctl_t;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic over;
        logic scan_end;
        logic found;
        logic split;
        logic dn_end;
        logic pos_bad;
        logic not_taken;
        logic f_more;
        logic join_lo;
        logic join_hi;
        logic full;
        logic up_done;
        logic out_free;
    } sts_t;

endpackage

[design/ffa_if.sv]
// ----------------------------------------------------------------------------
// ffa request / response channels
// Valid/ready channels carrying allocator commands and results.
// ----------------------------------------------------------------------------
interface ffa_req_if;
    logic                      valid;
    logic                      ready;
    logic [ffa_pkg::CMD_W-1:0] cmd;
    logic [ffa_pkg::SIZE_W-1:0] req_size;
    logic [ffa_pkg::OFF_W-1:0] free_offset;

    modport source (output valid, cmd, req_size, free_offset, input ready);
    modport sink   (input valid, cmd, req_size, free_offset, output ready);
endinterface

interface ffa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [ffa_pkg::STATUS_W-1:0] status;
    logic [ffa_pkg::OFF_W-1:0]    data_offset;
    logic [ffa_pkg::TOT_W-1:0]    free_total;
    logic [ffa_pkg::TOT_W-1:0]    used_total;

    modport source (output valid, status, data_offset, free_total, used_total,
                    input ready);
    modport sink   (input valid, status, data_offset, free_total, used_total,
                    output ready);
endinterface

[design/ffa_ctrl.sv]
// ----------------------------------------------------------------------------
// ffa_ctrl
// Sequencer for clearing, first-fit search, table shifts and result hand-off.
// ----------------------------------------------------------------------------
module ffa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ffa_pkg::sts_t sts,
    output ffa_pkg::ctl_t ctl
);
    import ffa_pkg::*;

    state_t              state_reg, state_next;
    logic [STATUS_W-1:0] code_reg, code_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            code_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        code_next  = code_reg;
        unique case (state_reg)
            S_CLEAR:    if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (sts.is_free)
                    state_next = S_F_CHK;
                else if (sts.over)
                begin
                    code_next  = ST_NOSPACE;
                    state_next = S_RES;
                end
                else
                    state_next = S_A_RD;
            end
            S_A_RD:
            begin
                if (sts.scan_end)
                begin
                    code_next  = ST_NOSPACE;
                    state_next = S_RES;
                end
                else
                    state_next = S_A_EVAL;
            end
            S_A_EVAL:
            begin
                if (!sts.found)
                    state_next = S_A_RD;
                else if (sts.split)
                    state_next = S_A_SPLIT;
                else
                    state_next = S_DN_RD;
            end
            S_A_SPLIT:  state_next = S_A_TAKE;
            S_A_TAKE:
            begin
                code_next  = ST_OK;
                state_next = S_RES;
            end
            S_DN_RD:
            begin
                if (!sts.dn_end)
                    state_next = S_DN_WR;
                else if (sts.is_free)
                    state_next = S_F_HDR;
                else
                    state_next = S_A_TAKE;
            end
            S_DN_WR:    state_next = S_DN_RD;
            S_F_CHK:
            begin
                if (sts.pos_bad)
                begin
                    code_next  = ST_BADFREE;
                    state_next = S_RES;
                end
                else
                    state_next = S_F_HDRCHK;
            end
            S_F_HDRCHK:
            begin
                if (sts.not_taken)
                begin
                    code_next  = ST_BADFREE;
                    state_next = S_RES;
                end
                else
                    state_next = S_F_RD;
            end
            S_F_RD:     state_next = S_F_EVAL;
            S_F_EVAL:
            begin
                if (sts.f_more)
                    state_next = S_F_RD;
                else if (!sts.join_lo && !sts.join_hi && sts.full)
                begin
                    code_next  = ST_BADFREE;
                    state_next = S_RES;
                end
                else if (sts.join_lo && sts.join_hi)
                    state_next = S_DN_RD;
                else if (sts.join_lo || sts.join_hi)
                    state_next = S_F_HDR;
                else
                    state_next = S_UP_RD;
            end
            S_UP_RD:    state_next = sts.up_done ? S_F_HDR : S_UP_WR;
            S_UP_WR:    state_next = S_UP_RD;
            S_F_HDR:
            begin
                code_next  = ST_OK;
                state_next = S_RES;
            end
            S_RES:      if (sts.out_free) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl.op     = OP_NONE;
        ctl.result = 1'b0;
        ctl.code   = code_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:    ctl.op = OP_CLEAR;
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    ctl.op = OP_LOAD;
            end
            S_A_EVAL:   ctl.op = sts.found ? OP_HIT : OP_NEXT;
            S_A_SPLIT:  ctl.op = OP_SPLIT;
            S_A_TAKE:   ctl.op = OP_TAKE;
            S_DN_RD:    ctl.op = sts.dn_end ? OP_DEC : OP_RD_NEXT;
            S_DN_WR:    ctl.op = OP_DN_WR;
            S_F_HDRCHK: ctl.op = sts.not_taken ? OP_NONE : OP_LATCH_SPAN;
            S_F_EVAL:
            begin
                if (sts.f_more)
                    ctl.op = OP_NEXT;
                else if (sts.join_lo || sts.join_hi || !sts.full)
                    ctl.op = OP_APPLY;
            end
            S_UP_RD:    ctl.op = sts.up_done ? OP_UP_INS : OP_RD_PREV;
            S_UP_WR:    ctl.op = OP_UP_WR;
            S_F_HDR:    ctl.op = OP_FREE_HDR;
            S_RES:      ctl.result = sts.out_free;
            default:    ctl.op = OP_NONE;
        endcase
    end

endmodule

[design/ffa_dpath.sv]
// ----------------------------------------------------------------------------
// ffa_dpath
// Node header memory, address-ordered free extent table and bookkeeping.
// ----------------------------------------------------------------------------
module ffa_dpath #(
    parameter int ARENA_BYTES       = 4096,
    parameter int MAX_EXTENTS       = 256,
    parameter int NODE_HEADER_BYTES = 4,
    parameter int MIN_PAYLOAD       = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ffa_pkg::ctl_t                ctl,
    output ffa_pkg::sts_t                sts,
    input  logic [ffa_pkg::CMD_W-1:0]    in_cmd,
    input  logic [ffa_pkg::SIZE_W-1:0]   in_req_size,
    input  logic [ffa_pkg::OFF_W-1:0]    in_free_offset,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ffa_pkg::STATUS_W-1:0] out_status,
    output logic [ffa_pkg::OFF_W-1:0]    out_data_offset,
    output logic [ffa_pkg::TOT_W-1:0]    out_free_total,
    output logic [ffa_pkg::TOT_W-1:0]    out_used_total
);
    import ffa_pkg::*;

    localparam int AW = $clog2(ARENA_BYTES);
    localparam int XW = ((AW > SIZE_W) ? AW : SIZE_W) + 2;
    localparam int EW = $clog2(MAX_EXTENTS);
    localparam int CW = EW + 1;

    localparam logic [XW-1:0] HDR_X     = XW'(NODE_HEADER_BYTES);
    localparam logic [XW-1:0] MIN_X     = XW'(MIN_PAYLOAD);
    localparam logic [XW-1:0] ARENA_X   = XW'(ARENA_BYTES);
    localparam logic [XW-1:0] PAYLOAD_X = XW'(ARENA_BYTES - NODE_HEADER_BYTES);
    localparam logic [XW-1:0] LEFT_X    = XW'(NODE_HEADER_BYTES + MIN_PAYLOAD);
    localparam logic [CW-1:0] MAX_C     = CW'(MAX_EXTENTS);
    localparam logic [AW-1:0] CLR_LAST  = AW'(ARENA_BYTES - 1);

    // header word: {taken, span}; extent word: {base, span}
    logic [AW:0]     hdr_mem [ARENA_BYTES];
    logic [2*AW-1:0] ext_mem [MAX_EXTENTS];

    logic [AW:0]     hdr_rd_reg;
    logic [2*AW-1:0] ext_rd_reg;

    logic            hdr_we;
    logic [AW-1:0]   hdr_wa;
    logic [AW:0]     hdr_wd;
    logic            ext_we;
    logic [EW-1:0]   ext_wa;
    logic [2*AW-1:0] ext_wd;
    logic [EW-1:0]   ext_ra;

    logic [CMD_W-1:0]  cmd_reg;
    logic [SIZE_W-1:0] req_reg;
    logic [OFF_W-1:0]  off_reg;
    logic [CW-1:0]     k_reg, k_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     free_reg, free_next;
    logic [AW-1:0]     clr_reg;
    logic [AW-1:0]     prev_base_reg, prev_span_reg;
    logic [AW-1:0]     hbase_reg, hspan_reg, tspan_reg, span_reg;
    logic              split_reg;
    logic              out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [OFF_W-1:0]  doff_reg;
    logic [TOT_W-1:0]  ftot_reg, utot_reg;

    logic [XW-1:0] want_x, pos_x, off_x, eb_x, es_x, sp_x;
    logic [AW-1:0] ext_base, ext_span, pos_a;
    logic [CW-1:0] k_inc, j_dec;
    logic          in_range;

    assign ext_base = ext_rd_reg[2*AW-1:AW];
    assign ext_span = ext_rd_reg[AW-1:0];
    assign eb_x     = XW'(ext_base);
    assign es_x     = XW'(ext_span);
    assign sp_x     = XW'(span_reg);
    assign want_x   = (XW'(req_reg) < MIN_X) ? MIN_X : XW'(req_reg);
    assign off_x    = XW'(off_reg);
    assign pos_x    = off_x - HDR_X;
    assign pos_a    = pos_x[AW-1:0];
    assign k_inc    = k_reg + CW'(1);
    assign j_dec    = j_reg - CW'(1);
    assign in_range = k_reg < count_reg;

    // status to the sequencer
    always_comb
    begin
        sts.clr_last  = clr_reg == CLR_LAST;
        sts.is_free   = cmd_reg == CMD_FREE;
        sts.over      = XW'(free_reg) < XW'(req_reg);
        sts.scan_end  = !in_range;
        sts.found     = es_x >= want_x;
        sts.split     = (es_x - want_x) >= LEFT_X;
        sts.dn_end    = k_inc >= count_reg;
        sts.pos_bad   = (off_x < HDR_X) || (pos_x >= ARENA_X);
        sts.not_taken = !hdr_rd_reg[AW];
        sts.f_more    = in_range && (eb_x <= pos_x);
        sts.join_lo   = (k_reg != '0)
                        && (XW'(prev_base_reg) + HDR_X + XW'(prev_span_reg) == pos_x);
        sts.join_hi   = in_range && (pos_x + HDR_X + sp_x == eb_x);
        sts.full      = count_reg >= MAX_C;
        sts.up_done   = j_reg == k_reg;
        sts.out_free  = !out_valid_reg || out_ready;
    end

    // memory write and read addressing
    always_comb
    begin
        hdr_we = 1'b0;
        hdr_wa = pos_a;
        hdr_wd = {1'b0, span_reg};
        ext_we = 1'b0;
        ext_wa = k_reg[EW-1:0];
        ext_wd = ext_rd_reg;
        ext_ra = k_reg[EW-1:0];
        unique case (ctl.op)
            OP_CLEAR:
            begin
                hdr_we = 1'b1;
                hdr_wa = clr_reg;
                hdr_wd = '0;
                ext_we = 1'b1;
                ext_wa = '0;
                ext_wd = {AW'(0), PAYLOAD_X[AW-1:0]};
            end
            OP_SPLIT:
            begin
                hdr_we = 1'b1;
                hdr_wa = AW'(XW'(hbase_reg) + HDR_X + want_x);
                hdr_wd = {1'b0, AW'(XW'(hspan_reg) - want_x - HDR_X)};
                ext_we = 1'b1;
                ext_wd = {AW'(XW'(hbase_reg) + HDR_X + want_x),
                          AW'(XW'(hspan_reg) - want_x - HDR_X)};
            end
            OP_TAKE:
            begin
                hdr_we = 1'b1;
                hdr_wa = hbase_reg;
                hdr_wd = {1'b1, tspan_reg};
            end
            OP_RD_NEXT: ext_ra = k_inc[EW-1:0];
            OP_DN_WR:   ext_we = 1'b1;
            OP_APPLY:
            begin
                if (sts.join_lo)
                begin
                    ext_we = 1'b1;
                    ext_wa = j_dec[EW-1:0] - EW'(count_reg - k_reg);
                    ext_wa = k_reg[EW-1:0] - EW'(1);
                    ext_wd = {prev_base_reg,
                              AW'(XW'(prev_span_reg) + sp_x + HDR_X
                                  + (sts.join_hi ? es_x + HDR_X : XW'(0)))};
                end
                else if (sts.join_hi)
                begin
                    ext_we = 1'b1;
                    ext_wd = {pos_a, AW'(es_x + sp_x + HDR_X)};
                end
            end
            OP_RD_PREV: ext_ra = j_dec[EW-1:0];
            OP_UP_WR:
            begin
                ext_we = 1'b1;
                ext_wa = j_reg[EW-1:0];
            end
            OP_UP_INS:
            begin
                ext_we = 1'b1;
                ext_wd = {pos_a, span_reg};
            end
            OP_FREE_HDR: hdr_we = 1'b1;
            default:     hdr_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hdr_we)
            hdr_mem[hdr_wa] <= hdr_wd;
        hdr_rd_reg <= hdr_mem[pos_a];
    end

    always_ff @(posedge clk)
    begin
        if (ext_we)
            ext_mem[ext_wa] <= ext_wd;
        ext_rd_reg <= ext_mem[ext_ra];
    end

    // bookkeeping next values
    always_comb
    begin
        k_next     = k_reg;
        j_next     = j_reg;
        count_next = count_reg;
        free_next  = free_reg;
        unique case (ctl.op)
            OP_LOAD:   k_next = '0;
            OP_NEXT:   k_next = k_inc;
            OP_DN_WR:  k_next = k_inc;
            OP_DEC:    count_next = count_reg - CW'(1);
            OP_TAKE:   free_next = AW'(XW'(free_reg) - XW'(tspan_reg)
                                       - (split_reg ? HDR_X : XW'(0)));
            OP_APPLY:
            begin
                j_next = count_reg;
                if (sts.join_lo && sts.join_hi)
                    free_next = AW'(XW'(free_reg) + sp_x + HDR_X + HDR_X);
                else if (sts.join_lo || sts.join_hi)
                    free_next = AW'(XW'(free_reg) + sp_x + HDR_X);
            end
            OP_UP_WR:  j_next = j_dec;
            OP_UP_INS:
            begin
                count_next = count_reg + CW'(1);
                free_next  = AW'(XW'(free_reg) + sp_x);
            end
            default:   k_next = k_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= '0;
            j_reg         <= '0;
            count_reg     <= CW'(1);
            free_reg      <= PAYLOAD_X[AW-1:0];
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg     <= k_next;
            j_reg     <= j_next;
            count_reg <= count_next;
            free_reg  <= free_next;
            if (ctl.op == OP_CLEAR)
                clr_reg <= clr_reg + AW'(1);
            if (ctl.result)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_LOAD)
        begin
            cmd_reg <= in_cmd;
            req_reg <= in_req_size;
            off_reg <= in_free_offset;
        end
        if (ctl.op == OP_NEXT)
        begin
            prev_base_reg <= ext_base;
            prev_span_reg <= ext_span;
        end
        if (ctl.op == OP_HIT)
        begin
            hbase_reg <= ext_base;
            hspan_reg <= ext_span;
            split_reg <= sts.split;
            tspan_reg <= sts.split ? want_x[AW-1:0] : ext_span;
        end
        if (ctl.op == OP_LATCH_SPAN)
            span_reg <= hdr_rd_reg[AW-1:0];
        if (ctl.result)
        begin
            status_reg <= ctl.code;
            doff_reg   <= (ctl.code == ST_OK && cmd_reg == CMD_ALLOC)
                          ? OFF_W'(XW'(hbase_reg) + HDR_X) : '0;
            ftot_reg   <= TOT_W'(free_reg);
            utot_reg   <= TOT_W'(PAYLOAD_X - XW'(free_reg));
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_status      = status_reg;
    assign out_data_offset = doff_reg;
    assign out_free_total  = ftot_reg;
    assign out_used_total  = utot_reg;

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_C)
        else $error("extent count above table depth");

    a_free_max: assert property (@(posedge clk) disable iff (!rst_n)
        XW'(free_reg) <= PAYLOAD_X)
        else $error("free bytes above arena payload");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.result && ctl.code != ST_OK |=> out_data_offset == '0)
        else $error("failed item carries a data offset");

    a_up_order: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.op == OP_UP_WR |-> j_reg > k_reg)
        else $error("table shift ran past insert point");

endmodule

[design/first_fit_heap_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over one arena with in-band node headers and coalescing.
// ----------------------------------------------------------------------------
// Allocate scans the extent table and may shift later entries down; free scans
//   it and may shift entries up or down.
// One item at a time; the extent table's one write port and one read port set the pace.
// Result sits in an output register; the next item is taken once it is loaded.
// Reset is asynchronous; a clearing pass over every word of the header memory
//   follows, with no item accepted until it ends.
module first_fit_heap_allocator #(
    parameter int ARENA_BYTES       = 4096,
    parameter int MAX_EXTENTS       = 256,
    parameter int NODE_HEADER_BYTES = 4,
    parameter int MIN_PAYLOAD       = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    ffa_req_if.sink   in,
    ffa_rsp_if.source out
);
    import ffa_pkg::*;

    ctl_t ctl;
    sts_t sts;

    ffa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in.valid),
        .in_ready (in.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    ffa_dpath #(
        .ARENA_BYTES       (ARENA_BYTES),
        .MAX_EXTENTS       (MAX_EXTENTS),
        .NODE_HEADER_BYTES (NODE_HEADER_BYTES),
        .MIN_PAYLOAD       (MIN_PAYLOAD)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .in_cmd          (in.cmd),
        .in_req_size     (in.req_size),
        .in_free_offset  (in.free_offset),
        .out_valid       (out.valid),
        .out_ready       (out.ready),
        .out_status      (out.status),
        .out_data_offset (out.data_offset),
        .out_free_total  (out.free_total),
        .out_used_total  (out.used_total)
    );

endmodule

[bench/first_fit_heap_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_tb
// Drives allocate/free items into the allocator and checks every result
// against a first-fit heap predictor with coalescing.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_tb;
    import ffa_pkg::*;

    localparam int ARENA    = 4096;
    localparam int MAX_EXT  = 256;
    localparam int HDR      = 4;
    localparam int MIN_PAY  = 8;
    localparam int PAYLOAD  = ARENA - HDR;
    localparam int LEFTOVER = HDR + MIN_PAY;
    localparam int N_RANDOM = 2000;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [SIZE_W-1:0] req_size;
        logic [OFF_W-1:0]  free_offset;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [OFF_W-1:0]    data_offset;
        logic [TOT_W-1:0]    free_total;
        logic [TOT_W-1:0]    used_total;
    } rsp_t;

    logic clk;
    logic rst_n;

    ffa_req_if req_ch ();
    ffa_rsp_if rsp_ch ();

    first_fit_heap_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (req_ch.sink),
        .out   (rsp_ch.source)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // heap shadow
    bit          node_taken [ARENA];
    int unsigned node_span  [ARENA];
    int unsigned ext_base   [MAX_EXT];
    int unsigned ext_span   [MAX_EXT];
    int unsigned ext_cnt;
    int unsigned free_bytes;
    int unsigned live_offsets[$];

    req_t pending_items[$];
    rsp_t expected_rsps[$];
    req_t cur_item;
    int   send_gap;
    int   recv_gap;
    int   err_count;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 60);
    endfunction

    task automatic drop_extent(input int unsigned k);
        for (int unsigned j = k; j + 1 < ext_cnt; j++)
        begin
            ext_base[j] = ext_base[j + 1];
            ext_span[j] = ext_span[j + 1];
        end
        ext_cnt--;
    endtask

    task automatic heap_alloc(input int unsigned req, output logic [STATUS_W-1:0] st,
                              output int unsigned where);
        int unsigned want;
        int unsigned k;
        int unsigned base;
        int unsigned span;
        st = ST_NOSPACE;
        where = 0;
        if (free_bytes < req)
            return;
        want = (req < MIN_PAY) ? MIN_PAY : req;
        for (k = 0; k < ext_cnt; k++)
            if (ext_span[k] >= want)
                break;
        if (k >= ext_cnt)
            return;
        base = ext_base[k];
        span = ext_span[k];
        free_bytes -= span;
        if (span - want >= LEFTOVER)
        begin
            ext_base[k] = base + HDR + want;
            ext_span[k] = span - want - HDR;
            free_bytes += ext_span[k];
            if (ext_base[k] < ARENA)
            begin
                node_taken[ext_base[k]] = 1'b0;
                node_span[ext_base[k]]  = ext_span[k];
            end
            span = want;
        end
        else
            drop_extent(k);
        node_taken[base] = 1'b1;
        node_span[base]  = span;
        where = base + HDR;
        st = ST_OK;
    endtask

    task automatic heap_release(input int unsigned off, output logic [STATUS_W-1:0] st);
        int unsigned pos;
        int unsigned span;
        int unsigned k;
        bit join_lo;
        bit join_hi;
        st = ST_BADFREE;
        if (off < HDR)
            return;
        pos = off - HDR;
        if (pos >= ARENA || !node_taken[pos])
            return;
        span = node_span[pos];
        for (k = 0; k < ext_cnt; k++)
            if (ext_base[k] > pos)
                break;
        join_lo = k > 0 && ext_base[k - 1] + HDR + ext_span[k - 1] == pos;
        join_hi = k < ext_cnt && pos + HDR + span == ext_base[k];
        if (!join_lo && !join_hi && ext_cnt >= MAX_EXT)
            return;
        node_taken[pos] = 1'b0;
        free_bytes += span;
        if (join_lo)
        begin
            ext_span[k - 1] += span + HDR;
            free_bytes += HDR;
            if (join_hi)
            begin
                ext_span[k - 1] += ext_span[k] + HDR;
                free_bytes += HDR;
                drop_extent(k);
            end
        end
        else if (join_hi)
        begin
            ext_base[k] = pos;
            ext_span[k] += span + HDR;
            free_bytes += HDR;
        end
        else
        begin
            for (int unsigned j = ext_cnt; j > k; j--)
            begin
                ext_base[j] = ext_base[j - 1];
                ext_span[j] = ext_span[j - 1];
            end
            ext_base[k] = pos;
            ext_span[k] = span;
            ext_cnt++;
        end
        st = ST_OK;
    endtask

    task automatic predict_heap(input req_t it);
        rsp_t        r;
        int unsigned where;
        where = 0;
        if (it.cmd == CMD_ALLOC)
        begin
            heap_alloc(it.req_size, r.status, where);
            if (r.status == ST_OK)
                live_offsets.push_back(where);
        end
        else
        begin
            heap_release(it.free_offset, r.status);
            if (r.status == ST_OK)
                foreach (live_offsets[i])
                    if (live_offsets[i] == it.free_offset)
                    begin
                        live_offsets.delete(i);
                        break;
                    end
        end
        r.data_offset = where[OFF_W-1:0];
        r.free_total  = free_bytes[TOT_W-1:0];
        r.used_total  = TOT_W'(PAYLOAD - free_bytes);
        expected_rsps.push_back(r);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid       <= 1'b0;
            req_ch.cmd         <= CMD_ALLOC;
            req_ch.req_size    <= '0;
            req_ch.free_offset <= '0;
            send_gap           <= 0;
        end
        else if (req_ch.valid && !req_ch.ready)
        begin
            // hold item
        end
        else
        begin
            if (req_ch.valid)
                predict_heap(cur_item);
            if (send_gap > 0)
            begin
                send_gap     <= send_gap - 1;
                req_ch.valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                cur_item            = pending_items.pop_front();
                req_ch.valid       <= 1'b1;
                req_ch.cmd         <= cur_item.cmd;
                req_ch.req_size    <= cur_item.req_size;
                req_ch.free_offset <= cur_item.free_offset;
                send_gap           <= pick_gap();
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t exp_r;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_gap     <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("result with no expectation waiting");
                    err_count++;
                end
                else
                begin
                    exp_r = expected_rsps.pop_front();
                    if (rsp_ch.status !== exp_r.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_r.status, rsp_ch.status);
                        err_count++;
                    end
                    if (rsp_ch.data_offset !== exp_r.data_offset)
                    begin
                        $error("data_offset: expected %0d, got %0d",
                               exp_r.data_offset, rsp_ch.data_offset);
                        err_count++;
                    end
                    if (rsp_ch.free_total !== exp_r.free_total)
                    begin
                        $error("free_total: expected %0d, got %0d",
                               exp_r.free_total, rsp_ch.free_total);
                        err_count++;
                    end
                    if (rsp_ch.used_total !== exp_r.used_total)
                    begin
                        $error("used_total: expected %0d, got %0d",
                               exp_r.used_total, rsp_ch.used_total);
                        err_count++;
                    end
                end
            end
            if (recv_gap > 0)
            begin
                recv_gap     <= recv_gap - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (rsp_ch.valid && rsp_ch.ready)
                    recv_gap <= pick_gap();
            end
        end
    end

    function automatic req_t mk_alloc(input int unsigned sz);
        req_t it;
        it.cmd         = CMD_ALLOC;
        it.req_size    = sz[SIZE_W-1:0];
        it.free_offset = OFF_W'($urandom);
        return it;
    endfunction

    function automatic req_t mk_free(input int unsigned off);
        req_t it;
        it.cmd         = CMD_FREE;
        it.req_size    = SIZE_W'($urandom);
        it.free_offset = off[OFF_W-1:0];
        return it;
    endfunction

    function automatic req_t random_item();
        int r;
        r = $urandom_range(0, 99);
        if (live_offsets.size() > 0 && r < 45)
        begin
            if ($urandom_range(0, 9) < 8)
                return mk_free(live_offsets[$urandom_range(0, live_offsets.size() - 1)]);
            return mk_free($urandom_range(0, ARENA - 1));
        end
        r = $urandom_range(0, 99);
        if (r < 70)
            return mk_alloc($urandom_range(0, 64));
        else if (r < 90)
            return mk_alloc($urandom_range(65, 600));
        return mk_alloc($urandom_range(0, 65535));
    endfunction

    initial
    begin
        err_count = 0;
        for (int i = 0; i < ARENA; i++)
        begin
            node_taken[i] = 1'b0;
            node_span[i]  = 0;
        end
        node_span[0] = PAYLOAD;
        ext_base[0]  = 0;
        ext_span[0]  = PAYLOAD;
        ext_cnt      = 1;
        free_bytes   = PAYLOAD;

        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // nodes at 0 (8), 12 (16), 32 (12); payloads at 4, 16, 36
        pending_items.push_back(mk_alloc(0));
        pending_items.push_back(mk_alloc(16));
        pending_items.push_back(mk_alloc(12));
        pending_items.push_back(mk_free(16));
        pending_items.push_back(mk_free(16));     // double free
        pending_items.push_back(mk_free(4));      // merges upward
        pending_items.push_back(mk_free(36));     // merges both sides
        pending_items.push_back(mk_alloc(65535));
        pending_items.push_back(mk_alloc(4093));
        pending_items.push_back(mk_alloc(4092));  // whole arena
        pending_items.push_back(mk_alloc(1));     // arena full
        pending_items.push_back(mk_free(4));
        pending_items.push_back(mk_alloc(4081));  // leftover too small to split
        pending_items.push_back(mk_free(4));
        pending_items.push_back(mk_alloc(4080));  // leftover just enough
        pending_items.push_back(mk_free(4));
        pending_items.push_back(mk_free(0));
        pending_items.push_back(mk_free(3));
        pending_items.push_back(mk_free(4095));
        pending_items.push_back(mk_free(10));
        pending_items.push_back(mk_alloc(7));
        pending_items.push_back(mk_free(4));

        for (int n = 0; n < N_RANDOM; n++)
        begin
            wait (pending_items.size() < 2);
            if (n == N_RANDOM / 2)
            begin
                wait (pending_items.size() == 0 && !req_ch.valid
                      && expected_rsps.size() == 0);
                repeat (40) @(posedge clk);
            end
            pending_items.push_back(random_item());
        end

        wait (pending_items.size() == 0 && !req_ch.valid && expected_rsps.size() == 0);
        repeat (2000) @(posedge clk);
        if (expected_rsps.size() != 0)
        begin
            $error("%0d expected results never arrived", expected_rsps.size());
            err_count++;
        end
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #300ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
